// ===== design/jase_pkg.sv =====
package jase_pkg;

    localparam logic [7:0] BYTE_FF  = 8'hFF;
    localparam logic [7:0] CODE_SOI = 8'hD8;
    localparam logic [7:0] CODE_EOI = 8'hD9;
    localparam logic [7:0] CODE_SOS = 8'hDA;
    localparam logic [7:0] CODE_APP_LO = 8'hE0;
    localparam logic [7:0] CODE_APP_HI = 8'hEF;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NOTJPEG = 3'd1;
    localparam logic [2:0] ST_BADMARK = 3'd2;
    localparam logic [2:0] ST_TRUNC   = 3'd3;
    localparam logic [2:0] ST_BADLEN  = 3'd4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_stream;
    } jase_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       segment_last;
        logic       stream_done;
        logic [2:0] status;
    } jase_out_t;

    // One queued command expands into one to three results, in the order
    // marker FF, data byte, end-of-stream status.
    typedef struct packed {
        logic       ff_en;
        logic       byte_en;
        logic       done_en;
        logic [7:0] data;
        logic       last;
        logic [2:0] status;
    } jase_cmd_t;

endpackage

// ===== design/jpeg_app_segment_extractor_top.sv =====
// Channel   Handshake                     Payload fields
// item      item_valid / item_stall       in_byte, end_of_stream
// result    result_valid / result_stall   out_byte, segment_last, stream_done, status
//
// The parser takes one byte per cycle while the queue has room and queues a command of one to three
// results for each byte that produces output; skipped bytes queue nothing. A result passes through
// the queue, the command register and the output register before it leaves. The output drains one
// result per cycle while result_stall is low, so an APP marker code (two results) or a final byte on
// one (three) backs up the queue briefly; item_stall rises only while the QUEUE_DEPTH-entry queue is
// full. Reset clears the parser, the queue and the valid flags of the command and output registers.
module jpeg_app_segment_extractor_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  jase_pkg::jase_in_t item,
    output logic               result_valid,
    input  logic               result_stall,
    output jase_pkg::jase_out_t result
);
    import jase_pkg::*;

    jase_cmd_t push_cmd;
    jase_cmd_t head_cmd;
    logic      push;
    logic      pop;
    logic      q_empty;
    logic      q_full;

    jase_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .push       (push),
        .cmd        (push_cmd),
        .full       (q_full)
    );

    jase_fifo #(
        .WIDTH ($bits(jase_cmd_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .pop       (pop),
        .pop_data  (head_cmd),
        .empty     (q_empty),
        .full      (q_full)
    );

    jase_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_data       (head_cmd),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ===== design/jase_fifo.sv =====
module jase_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty,
    output logic             full
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CNT_FULL);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== design/jase_front.sv =====
module jase_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  jase_pkg::jase_in_t  item,
    output logic                push,
    output jase_pkg::jase_cmd_t cmd,
    input  logic                full
);
    import jase_pkg::*;

    typedef enum logic [7:0] {
        PH_SOI0  = 8'b0000_0001,
        PH_SOI1  = 8'b0000_0010,
        PH_MFF   = 8'b0000_0100,
        PH_MCODE = 8'b0000_1000,
        PH_LENHI = 8'b0001_0000,
        PH_LENLO = 8'b0010_0000,
        PH_BODY  = 8'b0100_0000,
        PH_STOP  = 8'b1000_0000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic        app_reg, app_next;
    logic [7:0]  len_hi_reg, len_hi_next;
    logic [15:0] left_reg, left_next;
    logic [2:0]  stop_reg, stop_next;
    logic        accept;
    logic [7:0]  b;
    logic [15:0] len;

    assign item_stall = full;
    assign accept     = item_valid && !full;
    assign b          = item.in_byte;
    assign len        = {len_hi_reg, b};
    assign push       = accept && (cmd.ff_en || cmd.byte_en || cmd.done_en);

    always_comb
    begin
        phase_next  = phase_reg;
        app_next    = app_reg;
        len_hi_next = len_hi_reg;
        left_next   = left_reg;
        stop_next   = stop_reg;
        cmd         = '0;
        cmd.data    = b;

        unique case (phase_reg)
            PH_SOI0:
            begin
                if (b == BYTE_FF)
                begin
                    phase_next = PH_SOI1;
                end
                else
                begin
                    phase_next = PH_STOP;
                    stop_next  = ST_NOTJPEG;
                    app_next   = 1'b0;
                end
            end
            PH_SOI1:
            begin
                if (b == CODE_SOI)
                begin
                    phase_next = PH_MFF;
                end
                else
                begin
                    phase_next = PH_STOP;
                    stop_next  = ST_NOTJPEG;
                    app_next   = 1'b0;
                end
            end
            PH_MFF:
            begin
                if (b == BYTE_FF)
                begin
                    phase_next = PH_MCODE;
                end
                else
                begin
                    phase_next = PH_STOP;
                    stop_next  = ST_BADMARK;
                    app_next   = 1'b0;
                end
            end
            PH_MCODE:
            begin
                if (b == CODE_EOI || b == CODE_SOS)
                begin
                    phase_next = PH_STOP;
                    stop_next  = ST_OK;
                    app_next   = 1'b0;
                end
                else
                begin
                    app_next    = (b >= CODE_APP_LO) && (b <= CODE_APP_HI);
                    cmd.ff_en   = app_next;
                    cmd.byte_en = app_next;
                    phase_next  = PH_LENHI;
                end
            end
            PH_LENHI:
            begin
                len_hi_next = b;
                cmd.byte_en = app_reg;
                phase_next  = PH_LENLO;
            end
            PH_LENLO:
            begin
                if (len < 16'd2)
                begin
                    phase_next = PH_STOP;
                    stop_next  = ST_BADLEN;
                    app_next   = 1'b0;
                end
                else
                begin
                    left_next   = len - 16'd2;
                    cmd.byte_en = app_reg;
                    cmd.last    = (left_next == '0);
                    if (left_next == '0)
                    begin
                        app_next   = 1'b0;
                        phase_next = PH_MFF;
                    end
                    else
                    begin
                        phase_next = PH_BODY;
                    end
                end
            end
            PH_BODY:
            begin
                left_next   = left_reg - 16'd1;
                cmd.byte_en = app_reg;
                cmd.last    = (left_next == '0);
                if (left_next == '0)
                begin
                    app_next   = 1'b0;
                    phase_next = PH_MFF;
                end
            end
            PH_STOP:
            begin
                // ignore bytes until end of stream
            end
            default:
            begin
                phase_next = PH_STOP;
            end
        endcase

        if (item.end_of_stream)
        begin
            cmd.done_en = 1'b1;
            unique case (phase_next)
                PH_SOI0, PH_SOI1:          cmd.status = ST_NOTJPEG;
                PH_LENHI, PH_LENLO, PH_BODY: cmd.status = ST_TRUNC;
                PH_STOP:                   cmd.status = stop_next;
                default:                   cmd.status = ST_OK;
            endcase
            // restart for the next file
            phase_next  = PH_SOI0;
            app_next    = 1'b0;
            len_hi_next = '0;
            left_next   = '0;
            stop_next   = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SOI0;
            app_reg    <= 1'b0;
            len_hi_reg <= '0;
            left_reg   <= '0;
            stop_reg   <= ST_OK;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            app_reg    <= app_next;
            len_hi_reg <= len_hi_next;
            left_reg   <= left_next;
            stop_reg   <= stop_next;
        end
    end

endmodule

// ===== design/jase_back.sv =====
module jase_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  jase_pkg::jase_cmd_t q_data,
    output logic                pop,
    output logic                result_valid,
    input  logic                result_stall,
    output jase_pkg::jase_out_t result
);
    import jase_pkg::*;

    jase_cmd_t cur_reg, cur_next;
    logic      cur_valid_reg, cur_valid_next;
    jase_out_t out_reg, out_next;
    logic      out_valid_reg, out_valid_next;
    logic      out_load;
    logic      cur_free;
    logic      one_left;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    assign out_load = cur_valid_reg && (!out_valid_reg || !result_stall);
    assign one_left = $countones({cur_reg.ff_en, cur_reg.byte_en, cur_reg.done_en}) == 1;
    assign cur_free = !cur_valid_reg || (out_load && one_left);
    assign pop      = cur_free && !q_empty;

    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_next       = '0;
            priority if (cur_reg.ff_en)
            begin
                out_next.out_byte = BYTE_FF;
                cur_next.ff_en    = 1'b0;
            end
            else if (cur_reg.byte_en)
            begin
                out_next.out_byte     = cur_reg.data;
                out_next.segment_last = cur_reg.last;
                cur_next.byte_en      = 1'b0;
            end
            else
            begin
                out_next.stream_done = 1'b1;
                out_next.status      = cur_reg.status;
                cur_next.done_en     = 1'b0;
            end
        end

        if (cur_free)
        begin
            cur_valid_next = !q_empty;
            cur_next       = q_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

endmodule

// ===== verif/testbench.sv =====
module testbench;
    import jase_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 280;
    localparam int LONG_HOLD    = 200;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS  = 10;

    typedef enum logic [7:0] {
        P_SOI0    = 8'b0000_0001,
        P_SOI1    = 8'b0000_0010,
        P_MARK_FF = 8'b0000_0100,
        P_CODE    = 8'b0000_1000,
        P_LEN_HI  = 8'b0001_0000,
        P_LEN_LO  = 8'b0010_0000,
        P_BODY    = 8'b0100_0000,
        P_HALT    = 8'b1000_0000
    } parse_phase_t;

    typedef struct packed {
        logic [7:0] b;
        logic       eos;
        logic       typed;
        logic [2:0] st;
    } dir_row_t;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      item_valid;
    logic      item_stall;
    jase_in_t  item;
    logic      result_valid;
    logic      result_stall;
    jase_out_t result;

    // segment parser tracking state
    parse_phase_t p_phase;
    logic         p_app;
    logic [7:0]   p_len_hi;
    logic [15:0]  p_remain;
    logic [2:0]   p_halt_status;

    jase_out_t expected_results[$];
    jase_in_t  file_q[$];
    dir_row_t  dir_rows[$];

    int   mismatches = 0;
    int   cycle_count = 0;
    int   burst_left = 0;
    int   random_sent = 0;
    logic in_random_part = 1'b0;
    logic hold_off = 1'b0;

    jpeg_app_segment_extractor_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic reset_parser();
        p_phase       = P_SOI0;
        p_app         = 1'b0;
        p_len_hi      = 8'h00;
        p_remain      = 16'h0000;
        p_halt_status = ST_OK;
    endtask

    task automatic stop_parse(input logic [2:0] st);
        p_phase       = P_HALT;
        p_halt_status = st;
        p_app         = 1'b0;
    endtask

    task automatic add_result(input bit emit, input logic [7:0] b, input logic last,
                              input logic done, input logic [2:0] st);
        jase_out_t r;
        r.out_byte     = b;
        r.segment_last = last;
        r.stream_done  = done;
        r.status       = st;
        if (emit)
            expected_results = {expected_results, r};
    endtask

    // Advance the parser by one byte; queue what it passes through when emit is set.
    task automatic parse_byte(input jase_in_t it, input bit emit);
        logic [7:0]  b;
        logic [15:0] seg_len;
        logic [2:0]  fin;
        b = it.in_byte;
        seg_len = {p_len_hi, b};
        case (p_phase)
            P_SOI0:
                if (b == BYTE_FF) p_phase = P_SOI1; else stop_parse(ST_NOTJPEG);
            P_SOI1:
                if (b == CODE_SOI) p_phase = P_MARK_FF; else stop_parse(ST_NOTJPEG);
            P_MARK_FF:
                if (b == BYTE_FF) p_phase = P_CODE; else stop_parse(ST_BADMARK);
            P_CODE:
            begin
                if (b == CODE_EOI || b == CODE_SOS)
                    stop_parse(ST_OK);
                else
                begin
                    p_app = (b >= CODE_APP_LO && b <= CODE_APP_HI);
                    if (p_app)
                    begin
                        add_result(emit, BYTE_FF, 1'b0, 1'b0, ST_OK);
                        add_result(emit, b, 1'b0, 1'b0, ST_OK);
                    end
                    p_phase = P_LEN_HI;
                end
            end
            P_LEN_HI:
            begin
                p_len_hi = b;
                if (p_app)
                    add_result(emit, b, 1'b0, 1'b0, ST_OK);
                p_phase = P_LEN_LO;
            end
            P_LEN_LO:
            begin
                if (seg_len < 16'd2)
                    stop_parse(ST_BADLEN);
                else
                begin
                    p_remain = seg_len - 16'd2;
                    if (p_app)
                        add_result(emit, b, p_remain == 16'd0, 1'b0, ST_OK);
                    if (p_remain == 16'd0)
                    begin
                        p_app   = 1'b0;
                        p_phase = P_MARK_FF;
                    end
                    else
                        p_phase = P_BODY;
                end
            end
            P_BODY:
            begin
                p_remain = p_remain - 16'd1;
                if (p_app)
                    add_result(emit, b, p_remain == 16'd0, 1'b0, ST_OK);
                if (p_remain == 16'd0)
                begin
                    p_app   = 1'b0;
                    p_phase = P_MARK_FF;
                end
            end
            default:
                p_phase = P_HALT;
        endcase

        if (it.end_of_stream)
        begin
            case (p_phase)
                P_SOI0, P_SOI1:           fin = ST_NOTJPEG;
                P_LEN_HI, P_LEN_LO, P_BODY: fin = ST_TRUNC;
                P_HALT:                   fin = p_halt_status;
                default:                  fin = ST_OK;
            endcase
            add_result(emit, 8'h00, 1'b0, 1'b1, fin);
            reset_parser();
        end
    endtask

    // Offer one transaction, in bursts with random gaps; called and returns at a falling edge.
    task automatic send_item(input jase_in_t it, input bit typed = 1'b0,
                             input logic [2:0] typed_status = ST_OK);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 7);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        item       <= it;
        item_valid <= 1'b1;
        do @(posedge clk); while (item_stall);
        parse_byte(it, !typed);
        add_result(typed, 8'h00, 1'b0, 1'b1, typed_status);
        burst_left--;
        @(negedge clk);
    endtask

    task automatic add_byte(input logic [7:0] b);
        jase_in_t t;
        t.in_byte       = b;
        t.end_of_stream = 1'b0;
        file_q = {file_q, t};
    endtask

    function automatic logic [7:0] pick_code();
        logic [7:0] c;
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            c = 8'($urandom_range(CODE_APP_LO, CODE_APP_HI));
        else if (r == 9)
            c = BYTE_FF;
        else
        begin
            c = 8'($urandom_range(0, 255));
            while (c == CODE_EOI || c == CODE_SOS || (c >= CODE_APP_LO && c <= CODE_APP_HI))
                c = 8'($urandom_range(0, 255));
        end
        return c;
    endfunction

    // Build one file: mostly well-formed segment chains, some noise and broken endings.
    task automatic build_file();
        int kind;
        int ending;
        int seg_len;
        int k;
        logic [7:0] hi;
        logic [7:0] lo;
        file_q.delete();
        kind = $urandom_range(0, 99);
        if (kind < 10)
        begin
            add_byte($urandom_range(0, 1) ? BYTE_FF : 8'($urandom_range(0, 255)));
            repeat ($urandom_range(0, 7)) add_byte(8'($urandom_range(0, 255)));
        end
        else
        begin
            add_byte(BYTE_FF);
            add_byte(CODE_SOI);
            repeat ($urandom_range(0, 4))
            begin
                seg_len = $urandom_range(2, 12);
                add_byte(BYTE_FF);
                add_byte(pick_code());
                add_byte(8'(seg_len >> 8));
                add_byte(8'(seg_len));
                repeat (seg_len - 2) add_byte(8'($urandom_range(0, 255)));
            end
            ending = $urandom_range(0, 99);
            if (ending < 30)
            begin
                add_byte(BYTE_FF);
                add_byte(CODE_EOI);
                repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(0, 255)));
            end
            else if (ending < 45)
            begin
                add_byte(BYTE_FF);
                add_byte(CODE_SOS);
                repeat ($urandom_range(0, 4)) add_byte(8'($urandom_range(0, 255)));
            end
            else if (ending < 55)
            begin
                // end on a segment boundary
            end
            else if (ending < 60)
                add_byte(BYTE_FF);
            else if (ending < 75)
            begin
                // cut the stream inside a long segment
                hi = (ending == 74) ? 8'hFF : 8'($urandom_range(1, 255));
                lo = (ending == 74) ? 8'hFF : 8'($urandom_range(0, 255));
                k  = $urandom_range(0, 6);
                add_byte(BYTE_FF);
                add_byte(pick_code());
                if (k >= 1) add_byte(hi);
                if (k >= 2) add_byte(lo);
                repeat (k - 2) add_byte(8'($urandom_range(0, 255)));
            end
            else if (ending < 87)
            begin
                add_byte(8'($urandom_range(0, 254)));
                repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                add_byte(BYTE_FF);
                add_byte(pick_code());
                add_byte(8'h00);
                add_byte(8'($urandom_range(0, 1)));
                repeat ($urandom_range(0, 2)) add_byte(8'($urandom_range(0, 255)));
            end
        end
        file_q[$].end_of_stream = 1'b1;
    endtask

    function automatic dir_row_t step(input logic [7:0] b, input logic eos = 1'b0);
        dir_row_t r;
        r.b     = b;
        r.eos   = eos;
        r.typed = 1'b0;
        r.st    = ST_OK;
        return r;
    endfunction

    function automatic dir_row_t stop_at(input logic [7:0] b, input logic [2:0] st);
        dir_row_t r;
        r.b     = b;
        r.eos   = 1'b1;
        r.typed = 1'b1;
        r.st    = st;
        return r;
    endfunction

    task automatic report(input string what, input jase_out_t want, input jase_out_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
        begin
            $write("%0d: %s: expected byte %h last %b done %b status %0d, ", cycle_count, what,
                   want.out_byte, want.segment_last, want.stream_done, want.status);
            $display("got byte %h last %b done %b status %0d",
                     got.out_byte, got.segment_last, got.stream_done, got.status);
        end
    endtask

    jase_out_t want_r;

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
                report("unexpected transaction", '0, result);
            else
            begin
                want_r = expected_results.pop_front();
                // the byte field carries nothing in a status transaction
                if (result.segment_last !== want_r.segment_last
                    || result.stream_done !== want_r.stream_done
                    || result.status !== want_r.status
                    || (!want_r.stream_done && result.out_byte !== want_r.out_byte))
                    report("mismatch", want_r, result);
            end
        end
    end

    // Receiver: stall on a mix of patterns, plus one long hold-off in the random part.
    initial
    begin
        int mode;
        int span;
        int tick;
        logic stall_now;
        tick = 0;
        result_stall = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 64);
            repeat (span)
            begin
                @(negedge clk);
                tick++;
                case (mode)
                    0:       stall_now = 1'b0;
                    1:       stall_now = ($urandom_range(0, 3) == 0);
                    2:       stall_now = ($urandom_range(0, 3) != 0);
                    default: stall_now = (tick % 5) < 2;
                endcase
                result_stall <= hold_off | stall_now;
            end
        end
    end

    initial
    begin
        wait (in_random_part);
        repeat ($urandom_range(20, 60)) @(negedge clk);
        hold_off <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        jase_in_t cur;
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        reset_parser();

        dir_rows = '{
            // stream ends before the start marker is complete
            stop_at(BYTE_FF, ST_NOTJPEG),
            // wrong start byte, rest ignored
            step(8'h00), stop_at(CODE_SOI, ST_NOTJPEG),
            // APP with one body byte, FF as a plain segment code, then a non-FF marker byte
            step(BYTE_FF), step(CODE_SOI), step(BYTE_FF), step(CODE_APP_LO), step(8'h00),
            step(8'h03), step(8'hAB), step(BYTE_FF), step(BYTE_FF), step(8'h00), step(8'h02),
            stop_at(8'h41, ST_BADMARK),
            // zero length on the last APP code
            step(BYTE_FF), step(CODE_SOI), step(BYTE_FF), step(CODE_APP_HI), step(8'h00),
            stop_at(8'h00, ST_BADLEN),
            // end right on an APP marker code: three transactions from one byte
            step(BYTE_FF), step(CODE_SOI), step(BYTE_FF), step(8'hE1, 1'b1),
            // end right after a marker's FF
            step(BYTE_FF), step(CODE_SOI), stop_at(BYTE_FF, ST_OK)
        };

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            cur.in_byte       = dir_rows[i].b;
            cur.end_of_stream = dir_rows[i].eos;
            send_item(cur, dir_rows[i].typed, dir_rows[i].st);
        end

        in_random_part = 1'b1;
        while (random_sent < RANDOM_ITEMS)
        begin
            build_file();
            foreach (file_q[i])
                send_item(file_q[i]);
            random_sent += file_q.size();
        end
        item_valid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
